// ===== design/shaped_noise_dither_24bit_unit_macros.svh =====
// Assertion macros for the shaped noise dither unit.
`ifndef SHAPED_NOISE_DITHER_24BIT_UNIT_MACROS_SVH
`define SHAPED_NOISE_DITHER_24BIT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled in reset.
`define SDITH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled in reset.
`define SDITH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sdith_pkg.sv =====
// Shared constants, tap weights and generator function for the dither unit.
package sdith_pkg;

    localparam int SAMPLE_W = 32;
    localparam int RESULT_W = 24;
    localparam int WORD_W   = 32;
    localparam int TAPS     = 10;
    localparam int ACC_W    = 52;
    localparam int FRAC_W   = 48;

    localparam logic [WORD_W-1:0] SEED_RESET = 32'd17;

    localparam int TAP_WEIGHT [TAPS] = '{
        3998, -7209, 16384, -28180, 65536, -65536, 32768, -15073, 8258, 0
    };

    function automatic logic [WORD_W-1:0] xorshift_next(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] t;
        t = x ^ (x << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

endpackage

// ===== design/sdith_in_if.sv =====
// Input sample request channel.
interface sdith_in_if import sdith_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

// ===== design/sdith_out_if.sv =====
// Output result request channel.
interface sdith_out_if import sdith_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [RESULT_W-1:0] sample_out;
    logic                       clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

// ===== design/sdith_tap_cell.sv =====
// One transposed FIR tap: weighted noise word plus the partial sum of its neighbor.
module sdith_tap_cell import sdith_pkg::*; #(
    parameter int WEIGHT = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic [WORD_W-1:0]       noise_word,
    input  logic signed [ACC_W-1:0] sum_in,
    output logic signed [ACC_W-1:0] sum_out
);

    localparam logic signed [ACC_W-1:0] WT = ACC_W'(WEIGHT);

    logic signed [ACC_W-1:0] word_ext;
    logic signed [ACC_W-1:0] sum_reg;
    logic signed [ACC_W-1:0] sum_next;

    assign word_ext = ACC_W'(noise_word);
    assign sum_next = word_ext * WT + sum_in;
    assign sum_out  = sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (en)
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

// ===== design/shaped_noise_dither_24bit_unit.sv =====
// Shaped noise dither requantizer: Q1.31 sample in, OUT_BITS-bit saturated sample out.
// Takes one sample per clock unless the output channel stalls; an accepted request passes
// through stage A, which forms the dither and splits the sample, then stage B, which adds,
// floors and saturates into the output register. The 10-tap dither FIR is a transposed row
// of tap cells, each holding one partial sum of past xorshift32 words and passing it to its
// neighbor on every accepted sample, so each cell needs only one constant multiply and
// one add per cycle. Writing noise_seed reloads the generator but keeps the tap history;
// write it only while no sample is in flight. No clearing pass is needed after reset.
module shaped_noise_dither_24bit_unit import sdith_pkg::*; #(
    parameter int OUT_BITS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                noise_seed_we,
    input  logic [WORD_W-1:0]   noise_seed_wdata,
    sdith_in_if.sink            in_ch,
    sdith_out_if.source         out_ch
);

`include "shaped_noise_dither_24bit_unit_macros.svh"

    localparam int SHIFT_S = SAMPLE_W - OUT_BITS;
    localparam int ZERO_K  = 27862 >> (24 - OUT_BITS);
    localparam int F_W     = ACC_W + 1;
    localparam int Q_W     = F_W - FRAC_W;
    localparam int R_W     = OUT_BITS + 2;

    localparam logic signed [R_W-1:0] R_MAX = R_W'((1 << (OUT_BITS - 1)) - 1);
    localparam logic signed [R_W-1:0] R_MIN = ~R_MAX;

    logic [WORD_W-1:0] noise_word_reg;
    logic [WORD_W-1:0] noise_word_next;

    logic in_acc;
    logic a_adv;
    logic b_free;

    // tap cell chain, entry TAPS is the zero fed into the last cell
    logic signed [ACC_W-1:0] sum_chain [1:TAPS];

    logic signed [ACC_W-1:0]    word_ext;
    logic signed [ACC_W-1:0]    d_next;
    logic [FRAC_W-1:0]          frac_next;
    logic signed [OUT_BITS-1:0] hi_next;

    logic                       a_valid_reg;
    logic                       a_valid_next;
    logic signed [ACC_W-1:0]    d_reg;
    logic [FRAC_W-1:0]          frac_reg;
    logic signed [OUT_BITS-1:0] hi_reg;

    logic signed [F_W-1:0]      f_sum;
    logic signed [Q_W-1:0]      q_floor;
    logic signed [R_W-1:0]      r_full;
    logic signed [OUT_BITS-1:0] r_sat;
    logic                       clip_next;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [RESULT_W-1:0] sample_out_reg;
    logic                       clipped_reg;

    assign b_free      = !out_valid_reg || out_ch.ready;
    assign a_adv       = a_valid_reg && b_free;
    assign in_ch.ready = !a_valid_reg || b_free;
    assign in_acc      = in_ch.valid && in_ch.ready;

    // generator
    always_comb
    begin
        noise_word_next = noise_word_reg;
        if (noise_seed_we)
        begin
            noise_word_next = noise_seed_wdata;
        end
        else if (in_acc)
        begin
            noise_word_next = xorshift_next(noise_word_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_word_reg <= SEED_RESET;
        end
        else
        begin
            noise_word_reg <= noise_word_next;
        end
    end

    // dither FIR, taps 1..TAPS-1 as cells, tap 0 folded into stage A
    assign sum_chain[TAPS] = '0;

    for (genvar k = 1; k < TAPS; k++)
    begin : g_tap
        sdith_tap_cell #(
            .WEIGHT (TAP_WEIGHT[k])
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (in_acc),
            .noise_word (noise_word_reg),
            .sum_in     (sum_chain[k+1]),
            .sum_out    (sum_chain[k])
        );
    end

    // stage A
    assign word_ext = ACC_W'(noise_word_reg);
    assign d_next   = word_ext * ACC_W'(TAP_WEIGHT[0]) + sum_chain[1];
    assign hi_next  = OUT_BITS'(in_ch.sample_in >>> SHIFT_S);

    always_comb
    begin
        if (in_ch.sample_in == '0)
        begin
            frac_next = FRAC_W'(noise_word_reg) * FRAC_W'(ZERO_K);
        end
        else
        begin
            frac_next = FRAC_W'(in_ch.sample_in[SHIFT_S-1:0]) << (FRAC_W - SHIFT_S);
        end
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (in_acc)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_adv)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            d_reg    <= d_next;
            frac_reg <= frac_next;
            hi_reg   <= hi_next;
        end
    end

    // stage B: add, floor, saturate
    assign f_sum   = F_W'(d_reg) + F_W'(frac_reg);
    assign q_floor = f_sum[F_W-1:FRAC_W];
    assign r_full  = R_W'(hi_reg) + R_W'(q_floor);

    always_comb
    begin
        r_sat     = r_full[OUT_BITS-1:0];
        clip_next = 1'b0;
        if (r_full > R_MAX)
        begin
            r_sat     = R_MAX[OUT_BITS-1:0];
            clip_next = 1'b1;
        end
        else if (r_full < R_MIN)
        begin
            r_sat     = R_MIN[OUT_BITS-1:0];
            clip_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (a_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            sample_out_reg <= RESULT_W'(r_sat);
            clipped_reg    <= clip_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample_out = sample_out_reg;
    assign out_ch.clipped    = clipped_reg;

    `SDITH_ASSERT_NEXT(a_gen_step, in_acc && !noise_seed_we,
        noise_word_reg == xorshift_next($past(noise_word_reg)),
        "generator did not advance on accepted request")
    `SDITH_ASSERT_NOW(a_out_range, out_valid_reg,
        (R_W'(sample_out_reg) <= R_MAX) && (R_W'(sample_out_reg) >= R_MIN),
        "result outside output range")
    `SDITH_ASSERT_NOW(a_clip_bound, out_valid_reg && clipped_reg,
        (R_W'(sample_out_reg) == R_MAX) || (R_W'(sample_out_reg) == R_MIN),
        "clipped result not at a bound")
    `SDITH_ASSERT_NEXT(a_stage_hold, a_valid_reg && !a_adv,
        a_valid_reg && $stable(d_reg) && $stable(hi_reg),
        "stalled stage A lost its request")

endmodule
